FILE: hw/rtl/kohi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kohi_pkg
// Shared types and constants for the keyed offset hash index: table sizes,
// field widths, result codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package kohi_pkg;

    // table sizes (BUCKETS must be a power of two: bucket = hash mod BUCKETS)
    localparam int BUCKETS    = 4096;
    localparam int POOL_NODES = 4096;

    // derived widths
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);

    // field widths
    localparam int ID_W   = 32;
    localparam int YEAR_W = 16;
    localparam int KEY_W  = ID_W + YEAR_W;
    localparam int OFS_W  = 48;
    localparam int ST_W   = 2;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((KEY_W + OFS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ST_W + OFS_W + 7) / 8) * 8;

    // hash multiplier and the width the exact hash sum needs
    localparam int HASH_MUL = 31;
    localparam int HASH_W   = ID_W + 6;

    // operation selector
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // result codes
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_HEADW,
        S_NODEW,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clr_wr;      // write one empty bucket head
        logic    load_in;     // capture input item and its bucket
        logic    head_rd;     // read bucket head
        logic    ins_wr;      // link a new node at the chain head
        logic    node_rd;     // read a chain node
        logic    rd_next;     // node address from previous node, else from head
        logic    res_load;    // capture result
        t_status res_code;
        logic    res_ofs;     // result carries the matched node offset
        logic    out_load;    // move result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_lookup;
        logic full;
        logic head_zero;
        logic key_match;
        logic next_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/kohi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kohi_ctrl
// Sequencer for the hash index: head memory clearing after reset, input
// acceptance, bucket head read, insert or chain walk, and result hand-off.
// ----------------------------------------------------------------------------
module kohi_ctrl
    import kohi_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HEADW;
            end
            S_HEADW: begin
                if (!i_stat.is_lookup) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_DONE;
                    if (i_stat.full) begin
                        o_cmd.res_code = ST_FULL;
                    end else begin
                        o_cmd.ins_wr   = 1'b1;
                        o_cmd.res_code = ST_OK;
                    end
                end else if (i_stat.head_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_MISS;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state       = S_NODEW;
                end
            end
            S_NODEW: begin
                if (i_stat.key_match) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_OK;
                    o_cmd.res_ofs  = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.next_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_MISS;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/kohi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kohi_dp
// Datapath of the hash index: bucket head memory, node pool memories, pool
// fill count, item and result registers, and the output register.
// ----------------------------------------------------------------------------
module kohi_dp
    import kohi_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  wire                  i_func,
    input  wire [ID_W-1:0]       i_key_id,
    input  wire [YEAR_W-1:0]     i_key_year,
    input  wire [OFS_W-1:0]      i_offset_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [ST_W-1:0]      o_status,
    output logic [OFS_W-1:0]     o_offset_out
);

    // memories
    logic [LINK_W-1:0] r_head_mem [BUCKETS];
    logic [KEY_W-1:0]  r_nkey_mem [POOL_NODES];
    logic [OFS_W-1:0]  r_nofs_mem [POOL_NODES];
    logic [LINK_W-1:0] r_nnxt_mem [POOL_NODES];

    // registers
    logic [BKT_W-1:0]  r_clr_cnt;
    logic [LINK_W-1:0] r_used;
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [OFS_W-1:0]  r_ofs;
    logic [BKT_W-1:0]  r_bkt;
    logic [LINK_W-1:0] r_head_q;
    logic [KEY_W-1:0]  r_nkey_q;
    logic [OFS_W-1:0]  r_nofs_q;
    logic [LINK_W-1:0] r_nnxt_q;
    t_status           r_res_status;
    logic [OFS_W-1:0]  r_res_ofs;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [OFS_W-1:0]  r_out_ofs;

    logic [HASH_W-1:0] hash_sum;
    logic [LINK_W-1:0] rd_link;
    logic [LINK_W-1:0] rd_link_m1;
    logic [NODE_W-1:0] node_rd_addr;

    // bucket hash: (id*31 + year) mod BUCKETS
    assign hash_sum = HASH_W'(i_key_id) * HASH_W'(HASH_MUL) + HASH_W'(i_key_year);

    // chain node address: link minus one
    assign rd_link      = i_cmd.rd_next ? r_nnxt_q : r_head_q;
    assign rd_link_m1   = rd_link - LINK_W'(1);
    assign node_rd_addr = rd_link_m1[NODE_W-1:0];

    // status to controller
    always_comb begin
        o_stat.clr_last  = (r_clr_cnt == BKT_W'(BUCKETS - 1));
        o_stat.is_lookup = (r_func == FUNC_LOOKUP);
        o_stat.full      = (r_used == LINK_W'(POOL_NODES));
        o_stat.head_zero = (r_head_q == '0);
        o_stat.key_match = (r_nkey_q == r_key);
        o_stat.next_zero = (r_nnxt_q == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // clearing counter and pool fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_used    <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + BKT_W'(1);
            end
            if (i_cmd.ins_wr) begin
                r_used <= r_used + LINK_W'(1);
            end
        end
    end

    // bucket head memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_head_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.ins_wr) begin
            r_head_mem[r_bkt] <= r_used + LINK_W'(1);
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_head_mem[r_bkt];
        end
    end

    // node pool memories: new node at the fill count, registered chain read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_nkey_mem[r_used[NODE_W-1:0]] <= r_key;
            r_nofs_mem[r_used[NODE_W-1:0]] <= r_ofs;
            r_nnxt_mem[r_used[NODE_W-1:0]] <= r_head_q;
        end
        if (i_cmd.node_rd) begin
            r_nkey_q <= r_nkey_mem[node_rd_addr];
            r_nofs_q <= r_nofs_mem[node_rd_addr];
            r_nnxt_q <= r_nnxt_mem[node_rd_addr];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_key  <= {i_key_id, i_key_year};
            r_ofs  <= i_offset_in;
            r_bkt  <= hash_sum[BKT_W-1:0];
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_code;
            r_res_ofs    <= i_cmd.res_ofs ? r_nofs_q : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_ofs    <= r_res_ofs;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_offset_out = r_out_ofs;

endmodule
`default_nettype wire

FILE: hw/rtl/keyed_offset_hash_index_unit.sv
`default_nettype none
// An accepted item has its bucket head read in S_HEAD; in S_HEADW an insert
// is done or a lookup starts its chain walk, which goes on in S_NODEW.
// One item at a time: the result waits in S_DONE until the output is free,
// and the next item is accepted in the cycle after the result enters the
// output register. Synchronous active-low reset clears the bucket head
// memory in a pass over every bucket, during which no item is accepted.
// ----------------------------------------------------------------------------
// keyed_offset_hash_index_unit
// Chained hash index from (key_id, key_year) to a 48-bit file offset, with
// head insertion from a bounded node pool and chain-walk lookup.
// ----------------------------------------------------------------------------
module keyed_offset_hash_index_unit
    import kohi_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input items
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [IN_DATA_W-1:0]   s_tdata,   // key_id[31:0], key_year[47:32], offset_in[95:48]
    input  wire                   s_tuser,   // func[0]
    // result items
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], offset_out[49:2], zero[55:50]
);

    t_cmd              cmd;
    t_stat             stat;
    logic [ST_W-1:0]   out_status;
    logic [OFS_W-1:0]  out_offset;

    // sequencer
    kohi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // memories and registers
    kohi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (s_tuser),
        .i_key_id     (s_tdata[ID_W-1:0]),
        .i_key_year   (s_tdata[KEY_W-1:ID_W]),
        .i_offset_in  (s_tdata[KEY_W+OFS_W-1:KEY_W]),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_status     (out_status),
        .o_offset_out (out_offset)
    );

    // result packing
    assign m_tdata = OUT_DATA_W'({out_offset, out_status});

endmodule
`default_nettype wire

FILE: hw/rtl/kohi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kohi_checker
// Port-level checks of the hash index unit over time, bound to the top level.
// ----------------------------------------------------------------------------
module kohi_checker
    import kohi_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the clearing pass follows reset, no item taken
    a_clear_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("item accepted during head clearing");

    // one item at a time: not ready right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // only defined result codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[ST_W-1:0] == ST_OK) || (m_tdata[ST_W-1:0] == ST_MISS)
                     || (m_tdata[ST_W-1:0] == ST_FULL))
        else $error("undefined status code");

    // misses and refused inserts carry a zero offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[ST_W-1:0] != ST_OK) |-> (m_tdata[OUT_DATA_W-1:ST_W] == '0))
        else $error("nonzero offset on a miss or full result");

endmodule

bind keyed_offset_hash_index_unit kohi_checker u_kohi_checker (.*);
`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed offset hash index. Inserts and lookups
// go in on the input stream. A local copy of the chained table predicts the
// status and offset of every item, and each result on the output stream is
// compared against the oldest prediction. Random stall patterns run on both
// sides, with one long receiver hold-off and a full drain after each test.
// ----------------------------------------------------------------------------
module tb;
    import kohi_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 310;

    typedef struct {
        t_status               status;
        logic [OFS_W-1:0]      offset;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // key_id[31:0], key_year[47:32], offset_in[95:48]
    logic                  s_tuser = 1'b0; // func[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // status[1:0], offset_out[49:2], zero[55:50]

    // shadow copy of the chained table
    logic [LINK_W-1:0] shadow_heads [BUCKETS];
    logic [KEY_W-1:0]  shadow_key   [POOL_NODES];
    logic [OFS_W-1:0]  shadow_ofs   [POOL_NODES];
    logic [LINK_W-1:0] shadow_next  [POOL_NODES];
    int                shadow_used;

    t_answer           answer_q [$];
    logic [KEY_W-1:0]  stored_keys [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int err_count   = 0;
    int cycle_cnt   = 0;

    keyed_offset_hash_index_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side ready: long hold-off first, else random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_count++;
    endtask

    // compare each result item against the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("result item with no prediction: %h", m_tdata));
            end else begin
                want = answer_q.pop_front();
                if (m_tdata[ST_W-1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              m_tdata[ST_W-1:0], want.status));
                if (m_tdata[ST_W+OFS_W-1:ST_W] !== want.offset)
                    report_mismatch($sformatf("offset %h, predicted %h",
                                              m_tdata[ST_W+OFS_W-1:ST_W], want.offset));
            end
        end
    end

    function automatic int bucket_of(input logic [ID_W-1:0] id, input logic [YEAR_W-1:0] year);
        longint unsigned h;
        h = longint'(id) * HASH_MUL + longint'(year);
        return int'(h % BUCKETS);
    endfunction

    // insert or chain walk on the shadow table
    function automatic t_answer predict_answer(input logic func, input logic [ID_W-1:0] id,
                                               input logic [YEAR_W-1:0] year,
                                               input logic [OFS_W-1:0] ofs);
        t_answer          ans;
        int               b;
        int               link;
        int               steps;
        logic [KEY_W-1:0] key;
        b = bucket_of(id, year);
        key = {id, year};
        ans.status = ST_MISS;
        ans.offset = '0;
        if (func == FUNC_INSERT) begin
            if (shadow_used >= POOL_NODES) begin
                ans.status = ST_FULL;
            end else begin
                shadow_key[shadow_used]  = key;
                shadow_ofs[shadow_used]  = ofs;
                shadow_next[shadow_used] = shadow_heads[b];
                shadow_heads[b] = LINK_W'(shadow_used + 1);
                shadow_used++;
                ans.status = ST_OK;
            end
        end else begin
            link = shadow_heads[b];
            steps = 0;
            while (link != 0 && link <= POOL_NODES && steps < POOL_NODES) begin
                if (shadow_key[link-1] == key) begin
                    ans.status = ST_OK;
                    ans.offset = shadow_ofs[link-1];
                    break;
                end
                link = shadow_next[link-1];
                steps++;
            end
        end
        return ans;
    endfunction

    // offer one item, hold it until taken, then predict its result
    task automatic send_item(input logic func, input logic [ID_W-1:0] id,
                             input logic [YEAR_W-1:0] year, input logic [OFS_W-1:0] ofs);
        t_answer ans;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {ofs, year, id};
        do @(posedge i_clk); while (!s_tready);
        ans = predict_answer(func, id, year, ofs);
        answer_q.push_back(ans);
        if (func == FUNC_INSERT && ans.status == ST_OK)
            stored_keys.push_back({id, year});
    endtask

    // sender stops offering and waits for every predicted result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [OFS_W-1:0] random_offset();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly known keys and keys aimed at a few busy buckets, the rest random
    task automatic send_random_item();
        logic              func;
        logic [ID_W-1:0]   id;
        logic [YEAR_W-1:0] year;
        logic [KEY_W-1:0]  k;
        int                pick;
        int                hot;
        int                base;
        func = ($urandom_range(0, 1) == 1) ? FUNC_LOOKUP : FUNC_INSERT;
        pick = $urandom_range(0, 99);
        id   = $urandom;
        year = 16'($urandom_range(0, 65535));
        if (pick < 50 && stored_keys.size() != 0) begin
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            id   = k[KEY_W-1:YEAR_W];
            year = k[YEAR_W-1:0];
        end else if (pick < 80) begin
            hot  = $urandom_range(0, 3) * 1000 + 5;
            base = bucket_of(id, '0);
            year = 16'(((hot - base) % BUCKETS + BUCKETS) % BUCKETS
                       + BUCKETS * $urandom_range(0, 15));
        end
        send_item(func, id, year, random_offset());
    endtask

    // empty table, key extremes, bucket collisions, duplicates, a long chain
    task automatic test_directed();
        int k;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(FUNC_LOOKUP, '0, '0, random_offset());
        send_item(FUNC_INSERT, '0, '0, '0);
        send_item(FUNC_LOOKUP, '0, '0, '1);
        send_item(FUNC_INSERT, '1, '1, '1);
        send_item(FUNC_LOOKUP, '1, '1, '0);
        // (1,0) and (0,31) share a bucket
        send_item(FUNC_INSERT, 32'd1, 16'd0, 48'h0123_4567_89ab);
        send_item(FUNC_LOOKUP, 32'd0, 16'd31, random_offset());
        send_item(FUNC_INSERT, 32'd0, 16'd31, 48'hfedc_ba98_7654);
        send_item(FUNC_LOOKUP, 32'd1, 16'd0, random_offset());
        // duplicate key, newest offset wins
        send_item(FUNC_INSERT, 32'd1, 16'd0, 48'h5a5a_a5a5_5a5a);
        send_item(FUNC_LOOKUP, 32'd1, 16'd0, random_offset());
        // ids that are multiples of the bucket count pile into one chain
        for (k = 1; k <= 8; k++)
            send_item(FUNC_INSERT, 32'(k) << BKT_W, 16'd7, random_offset());
        send_item(FUNC_LOOKUP, 32'd1 << BKT_W, 16'd7, random_offset());
        send_item(FUNC_LOOKUP, 32'd9 << BKT_W, 16'd7, random_offset());
        wait_drained();
    endtask

    // random traffic under one stall pattern, drained halfway through
    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_item();
            if (n == ITEMS_PER_PHASE / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int n;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 300;
        for (n = 0; n < 16; n++)
            send_random_item();
        wait_drained();
    endtask

    initial begin
        int b;
        for (b = 0; b < BUCKETS; b++)
            shadow_heads[b] = '0;
        shadow_used = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(30, 80);
        test_random_phase(80, 30);
        test_random_phase(0, 0);
        test_backpressure();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (answer_q.size() != 0)
            report_mismatch($sformatf("%0d predictions never answered", answer_q.size()));
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
